// ===== rtl/lcgn_pkg.sv =====
package lcgn_pkg;

  // Field widths
  localparam int unsigned OpW   = 2;
  localparam int unsigned SeedW = 27;
  localparam int unsigned CutW  = 30;
  localparam int unsigned DrawW = 31;
  localparam int unsigned SumW  = 31;

  // Generator rule s' = (LcgMul*s + LcgAdd) mod LcgMod
  localparam logic [31:0] LcgMul    = 32'd19;
  localparam logic [31:0] LcgAdd    = 32'd656329;
  localparam logic [31:0] LcgMod    = 32'd100000001;
  localparam logic [31:0] ReseedOfs = 32'd54321;

  // Normal draw
  localparam int unsigned NormTerms   = 12;
  localparam logic [31:0] NormOfs     = 32'd600000000;
  localparam int unsigned MaxTriesDef = 100;

  typedef enum logic [OpW-1:0] {
    OP_LOAD    = 2'd0,
    OP_RESEED  = 2'd1,
    OP_UNIFORM = 2'd2,
    OP_NORMAL  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_OFS,
    ST_CHECK,
    ST_DONE
  } st_e;

  // Command into the shared modular unit
  typedef struct packed {
    logic             go;
    logic             step;  // 1: multiply-add step, 0: add reseed offset
    logic [SeedW-1:0] x;
  } red_cmd_t;

  typedef struct packed {
    logic             done;
    logic [SeedW-1:0] value;
  } red_res_t;

  // Finished result from the sequencer
  typedef struct packed {
    logic                    fire;
    logic signed [DrawW-1:0] value;
    logic                    fail;
  } draw_t;

  // Multiples of LcgMod just below i*2^24, indexed by the top byte of a 32-bit word
  typedef logic [31:0] qm_tbl_t [256];

  function automatic qm_tbl_t build_qm_tbl();
    qm_tbl_t tbl;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = 32'(((longint'(i) << 24) / LcgMod) * LcgMod);
    end
    return tbl;
  endfunction

  localparam qm_tbl_t QmTbl = build_qm_tbl();

endpackage

// ===== rtl/lcgn_if.sv =====
interface lcgn_req_if;
  import lcgn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       opcode;
  logic [SeedW-1:0]     seed_value;

  modport source (output valid, opcode, seed_value, input ready);
  modport sink   (input valid, opcode, seed_value, output ready);
endinterface

interface lcgn_rsp_if;
  import lcgn_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DrawW-1:0] draw_value;
  logic                    no_convergence;

  modport source (output valid, draw_value, no_convergence, input ready);
  modport sink   (input valid, draw_value, no_convergence, output ready);
endinterface

interface lcgn_cfg_if;
  import lcgn_pkg::*;
  logic            valid;
  logic            ready;
  logic [CutW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/lcg_uniform_and_clipped_normal_core.sv =====
// Congruential random source with uniform and clipped normal draws. Both seeds
// advance by s' = (19*s + 656329) mod 100000001 through one shared modular
// unit (multiply-add, table subtract, final compare-subtract), one generator
// step at a time. Opcodes on the request word: load writes both seeds and
// returns zero; reseed steps the base seed, sets current = base + 54321 mod m,
// and returns zero; uniform steps the current seed and returns it (units of
// 1e-8); normal sums twelve steps, subtracts 6e8, and redraws while the
// magnitude exceeds cut_magnitude. After MaxTries rejected attempts one more
// attempt is drawn and dropped, and the word comes back with no_convergence
// set and draw_value zero. The request side is busy for the whole item; a
// normal draw takes twelve generator steps plus the acceptance check per
// attempt. A finished word sits in the output register while the next
// request is taken. The cut register is written through the configuration
// port, which is always ready; write it only while the block is idle.
// Reset zeroes both seeds and the cut.
module lcg_uniform_and_clipped_normal_core #(
  parameter int unsigned MaxTries = lcgn_pkg::MaxTriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcgn_req_if.sink   req_i,
  lcgn_rsp_if.source rsp_o,
  lcgn_cfg_if.sink   cfg_i
);
  import lcgn_pkg::*;

  logic [CutW-1:0]         cut_q;
  logic                    rsp_valid_q;
  logic signed [DrawW-1:0] draw_q;
  logic                    nconv_q;
  logic                    out_free;

  red_cmd_t red_cmd;
  red_res_t red_res;
  draw_t    draw;

  // Configuration: single register, never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= '0;
    end else if (cfg_i.valid) begin
      cut_q <= cfg_i.data;
    end
  end

  // Output register frees when empty or when the held word is taken
  assign out_free = !rsp_valid_q || rsp_o.ready;

  lcgn_ctrl #(
    .MaxTries (MaxTries)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .opcode_i     (req_i.opcode),
    .seed_value_i (req_i.seed_value),
    .in_ready_o   (req_i.ready),
    .cut_i        (cut_q),
    .out_free_i   (out_free),
    .red_cmd_o    (red_cmd),
    .red_res_i    (red_res),
    .draw_o       (draw)
  );

  lcgn_reduce u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .red_cmd_i (red_cmd),
    .red_res_o (red_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (draw.fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Hold the payload until a new word replaces it
  always_ff @(posedge clk_i) begin
    if (draw.fire) begin
      draw_q  <= draw.value;
      nconv_q <= draw.fail;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.draw_value     = draw_q;
  assign rsp_o.no_convergence = nconv_q;

endmodule

// ===== rtl/lcgn_reduce.sv =====
// Shared modular unit: forms the operand, subtracts a table multiple of the
// modulus, then one final compare-subtract. Go reaches done through v1_q and v2_q.
module lcgn_reduce (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcgn_pkg::red_cmd_t  red_cmd_i,
  output lcgn_pkg::red_res_t  red_res_o
);
  import lcgn_pkg::*;

  localparam logic [SeedW-1:0] ModS = SeedW'(LcgMod);

  logic [31:0]      t_d, t_q;
  logic [SeedW-1:0] r_d, r_q;
  logic [31:0]      diff;
  logic             v1_q, v2_q;

  assign t_d = red_cmd_i.step ? (32'(red_cmd_i.x) * LcgMul + LcgAdd)
                              : (32'(red_cmd_i.x) + ReseedOfs);

  // Remainder after the table subtract stays below 2^24 + modulus
  assign diff = t_q - QmTbl[t_q[31:24]];
  assign r_d  = diff[SeedW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= red_cmd_i.go;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (red_cmd_i.go) begin
      t_q <= t_d;
    end
    if (v1_q) begin
      r_q <= r_d;
    end
  end

  assign red_res_o.done  = v2_q;
  assign red_res_o.value = (r_q >= ModS) ? (r_q - ModS) : r_q;

endmodule

// ===== rtl/lcgn_ctrl.sv =====
// Sequencer: holds both seeds, the normal sum and the attempt counters, and
// drives the shared modular unit one generator step at a time.
module lcgn_ctrl #(
  parameter int unsigned MaxTries = lcgn_pkg::MaxTriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [lcgn_pkg::OpW-1:0]     opcode_i,
  input  logic [lcgn_pkg::SeedW-1:0]   seed_value_i,
  output logic                         in_ready_o,
  input  logic [lcgn_pkg::CutW-1:0]    cut_i,
  input  logic                         out_free_i,
  output lcgn_pkg::red_cmd_t           red_cmd_o,
  input  lcgn_pkg::red_res_t           red_res_i,
  output lcgn_pkg::draw_t              draw_o
);
  import lcgn_pkg::*;

  localparam int unsigned TryW  = $clog2(MaxTries + 1);
  localparam int unsigned TermW = $clog2(NormTerms);
  localparam logic [TermW-1:0] LastTerm = TermW'(NormTerms - 1);
  localparam logic [TryW-1:0]  LastTry  = TryW'(MaxTries);

  st_e                     state_q, state_d;
  op_e                     op_q, in_op;
  logic [SeedW-1:0]        base_q, cur_q;
  logic [SumW-1:0]         sum_q;
  logic [TermW-1:0]        term_q;
  logic [TryW-1:0]         try_q;
  logic signed [DrawW-1:0] val_q;
  logic                    fail_q;

  logic                    accept_in;
  logic signed [31:0]      f_dev, f_neg, cut_s;
  logic                    hit, last_try;

  assign in_op     = op_e'(opcode_i);
  assign accept_in = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);

  // Attempt accepted when both signed distances are within the cut
  assign f_dev    = $signed({1'b0, sum_q}) - $signed(NormOfs);
  assign f_neg    = $signed(NormOfs) - $signed({1'b0, sum_q});
  assign cut_s    = $signed({2'b00, cut_i});
  assign hit      = (f_dev <= cut_s) && (f_neg <= cut_s);
  assign last_try = (try_q == LastTry);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          state_d = (in_op == OP_LOAD) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (red_res_i.done) begin
          case (op_q)
            OP_RESEED:  state_d = ST_OFS;
            OP_NORMAL:  state_d = (term_q == LastTerm) ? ST_CHECK : ST_RUN;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_OFS: begin
        if (red_res_i.done) begin
          state_d = ST_DONE;
        end
      end
      ST_CHECK: begin
        state_d = (hit || last_try) ? ST_DONE : ST_RUN;
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    red_cmd_o.go   = 1'b0;
    red_cmd_o.step = 1'b1;
    red_cmd_o.x    = cur_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_in && in_op != OP_LOAD) begin
          red_cmd_o.go = 1'b1;
          red_cmd_o.x  = (in_op == OP_RESEED) ? base_q : cur_q;
        end
      end
      ST_RUN: begin
        if (red_res_i.done) begin
          if (op_q == OP_RESEED) begin
            red_cmd_o.go   = 1'b1;
            red_cmd_o.step = 1'b0;
            red_cmd_o.x    = red_res_i.value;
          end else if (op_q == OP_NORMAL && term_q != LastTerm) begin
            red_cmd_o.go = 1'b1;
            red_cmd_o.x  = red_res_i.value;
          end
        end
      end
      ST_CHECK: begin
        if (!(hit || last_try)) begin
          red_cmd_o.go = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign draw_o.fire  = (state_q == ST_DONE) && out_free_i;
  assign draw_o.value = val_q;
  assign draw_o.fail  = fail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_LOAD;
      base_q <= '0;
      cur_q  <= '0;
      sum_q  <= '0;
      term_q <= '0;
      try_q  <= '0;
      val_q  <= '0;
      fail_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept_in) begin
            op_q   <= in_op;
            sum_q  <= '0;
            term_q <= '0;
            try_q  <= '0;
            val_q  <= '0;
            fail_q <= 1'b0;
            if (in_op == OP_LOAD) begin
              base_q <= seed_value_i;
              cur_q  <= seed_value_i;
            end
          end
        end
        ST_RUN: begin
          if (red_res_i.done) begin
            case (op_q)
              OP_RESEED: base_q <= red_res_i.value;
              OP_UNIFORM: begin
                cur_q <= red_res_i.value;
                val_q <= $signed({4'b0000, red_res_i.value});
              end
              OP_NORMAL: begin
                cur_q  <= red_res_i.value;
                sum_q  <= sum_q + SumW'(red_res_i.value);
                term_q <= (term_q == LastTerm) ? '0 : term_q + 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_OFS: begin
          if (red_res_i.done) begin
            cur_q <= red_res_i.value;
          end
        end
        ST_CHECK: begin
          if (last_try) begin
            val_q  <= '0;
            fail_q <= 1'b1;
          end else if (hit) begin
            val_q <= $signed(f_dev[DrawW-1:0]);
          end else begin
            try_q  <= try_q + 1'b1;
            sum_q  <= '0;
            term_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
